FILE: sv/mandelbrot_escape_time_pixel_core_defines.svh
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel core: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_CORE_DEFINES_SVH

// same-cycle implication
`define MBET_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBET_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mbet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_pkg
// Types, constants and saturation helper for the Mandelbrot pixel core.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // default sizes
  localparam int unsigned DEF_MAX_ITER   = 50;
  localparam int unsigned DEF_IMG_WIDTH  = 1920;
  localparam int unsigned DEF_IMG_HEIGHT = 1920;

  // fixed point format: signed Q8.24
  localparam int FRAC_BITS = 24;
  localparam int Q_W       = 32;
  localparam int PIX_W     = 11;
  localparam int DIV_W     = PIX_W + FRAC_BITS;  // pixel << 24
  localparam int SAT_W     = 48;                 // pre-saturation width
  localparam int CFG_IDX_W = 2;

  localparam logic [SAT_W-1:0] Q_HALF_W   = SAT_W'(1) << (FRAC_BITS - 1);
  localparam logic [63:0]      ESCAPE_MAG = 64'd20 << (2 * FRAC_BITS);

  // color constants
  localparam int unsigned COLOR_BASE   = 32'h009136DF;
  localparam logic [31:0] COLOR_ALPHA  = 32'h000000FF;
  localparam logic [31:0] COLOR_INSIDE = 32'h9136DFFF;

  localparam logic [31:0] INV_SCALE_RST = 32'd55924053;

  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_SCALE = 2'd0,
    REG_OFFSET_X  = 2'd1,
    REG_OFFSET_Y  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic        [Q_W-1:0] inverse_scale;
    logic signed [Q_W-1:0] offset_x;
    logic signed [Q_W-1:0] offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [Q_W-1:0] re;
    logic signed [Q_W-1:0] im;
  } coord_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // clamp to signed Q8.24
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if ((&v[SAT_W-1:Q_W-1]) || !(|v[SAT_W-1:Q_W-1])) r = v[Q_W-1:0];
    else if (v[SAT_W-1]) r = {1'b1, {(Q_W-1){1'b0}}};
    else r = {1'b0, {(Q_W-1){1'b1}}};
    return r;
  endfunction

endpackage

FILE: sv/mbet_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_div
// Constant divide by reciprocal multiplication: (num << 24) / DIVISOR,
// exact for every 11-bit num; input register, then a registered multiply.
// ----------------------------------------------------------------------------
module mbet_div import mbet_pkg::*; #(
  parameter int unsigned DIVISOR = DEF_IMG_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [PIX_W-1:0] num,
  output logic             busy,
  output logic [DIV_W-1:0] quo
);

  // M = ceil(2^(DIV_W+SH) / DIVISOR) keeps floor(n*M) exact for n < 2^DIV_W
  localparam int SH = $clog2(DIVISOR);
  localparam int RW = DIV_W + 1;
  localparam int MW = PIX_W + RW;
  localparam logic [63:0] RECIP_64 =
    ((64'd1 << (DIV_W + SH)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_64);

  logic [PIX_W-1:0] num_q;
  logic [MW-1:0]    prod;

  // control: busy flags the step in which the product is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) num_q <= num;
    if (busy) prod <= num_q * RECIP;
  end

  // the 2^24 of the dividend folds into the shift
  assign quo = DIV_W'(prod >> (PIX_W + SH));

endmodule

FILE: sv/mbet_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_front
// Takes a pixel beat, divides by the image size, scales by the inverse
// scale, subtracts the offsets and pushes the point c into the queue.
// ----------------------------------------------------------------------------
module mbet_front import mbet_pkg::*; #(
  parameter int unsigned IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int unsigned IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] pixel_x,
  input  logic [PIX_W-1:0] pixel_y,
  input  cfg_t             cfg,
  input  q_stat_t          q_stat,
  output logic             push,
  output coord_t           coord
);

  typedef enum logic [2:0] {F_IDLE, F_DIV, F_MX, F_MY, F_FIN, F_PUSH} state_t;

  state_t                state;
  logic                  accept;
  logic                  busy_x;
  logic                  busy_y;
  logic [DIV_W-1:0]      quo_x;
  logic [DIV_W-1:0]      quo_y;
  logic signed [Q_W-1:0] ux;
  logic signed [Q_W-1:0] uy;
  logic signed [Q_W-1:0] mul_a;
  logic signed [63:0]    prod;

  // floor(prod / 2^24) - off, clamped
  function automatic logic signed [Q_W-1:0] cmap(input logic signed [63:0] p,
                                                 input logic signed [Q_W-1:0] off);
    logic signed [SAT_W-1:0] t;
    t = {{(SAT_W-64+FRAC_BITS){p[63]}}, p[63:FRAC_BITS]}
        - {{(SAT_W-Q_W){off[Q_W-1]}}, off};
    return sat_q(t);
  endfunction

  assign accept   = in_valid && (state == F_IDLE);
  assign in_stall = (state != F_IDLE);
  assign push     = (state == F_PUSH) && !q_stat.full;
  assign mul_a    = (state == F_MX) ? ux : uy;

  mbet_div #(.DIVISOR(IMG_WIDTH)) u_div_x (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .num  (pixel_x),
    .busy (busy_x),
    .quo  (quo_x)
  );

  mbet_div #(.DIVISOR(IMG_HEIGHT)) u_div_y (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .num  (pixel_y),
    .busy (busy_y),
    .quo  (quo_y)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (accept) state <= F_DIV;
        F_DIV:  if (!busy_x && !busy_y) state <= F_MX;
        F_MX:   state <= F_MY;
        F_MY:   state <= F_FIN;
        F_FIN:  state <= F_PUSH;
        F_PUSH: if (!q_stat.full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // mapping datapath: one shared multiplier, registered
  always_ff @(posedge clk) begin
    case (state)
      F_DIV: begin
        ux <= sat_q($signed(SAT_W'(quo_x) - Q_HALF_W));
        uy <= sat_q($signed(SAT_W'(quo_y) - Q_HALF_W));
      end
      F_MX: prod <= mul_a * $signed({1'b0, cfg.inverse_scale});
      F_MY: begin
        coord.re <= cmap(prod, cfg.offset_x);
        prod     <= mul_a * $signed({1'b0, cfg.inverse_scale});
      end
      F_FIN: coord.im <= cmap(prod, cfg.offset_y);
      default: ;
    endcase
  end

endmodule

FILE: sv/mbet_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_queue
// Short FIFO of mapped points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module mbet_queue import mbet_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  coord_t  din,
  input  logic    pop,
  output coord_t  dout,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  coord_t        slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] cnt;

  assign q_stat.full  = (cnt == CW'(DEPTH));
  assign q_stat.empty = (cnt == '0);
  assign dout         = slots[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

endmodule

FILE: sv/mbet_iter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbet_iter
// Iteration engine: z = z*z + c, each step a multiply state, then an update and
// test state, color tracked step by step, result held in an output register.
// ----------------------------------------------------------------------------
module mbet_iter import mbet_pkg::*; #(
  parameter int unsigned MAX_ITER = DEF_MAX_ITER
) (
  input  logic        clk,
  input  logic        rst,
  input  q_stat_t     q_stat,
  input  coord_t      qdata,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  escape_step,
  output logic        escaped,
  output logic [31:0] rgba_color
);

  localparam int IW  = $clog2(MAX_ITER + 1);
  localparam int CRW = $clog2(MAX_ITER) + 1;
  localparam int unsigned COLOR_Q_STEP = COLOR_BASE / MAX_ITER;
  localparam int unsigned COLOR_R_STEP = COLOR_BASE % MAX_ITER;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_UPD, B_DONE} state_t;

  state_t                  state;
  logic signed [Q_W-1:0]   zr, zi, cr, ci;
  logic signed [63:0]      prr, pii, pri;
  logic signed [63:0]      diff;
  logic signed [SAT_W-1:0] re_t, im_t;
  logic signed [Q_W-1:0]   nr, ni;
  logic [63:0]             mag;
  logic                    esc_now;
  logic                    first;
  logic                    hit;
  logic                    last;
  logic                    out_free;
  logic [IW-1:0]           step;
  logic [23:0]             colq;
  logic [CRW-1:0]          colr;
  logic [CRW-1:0]          r_sum;
  logic                    r_wrap;

  // update and magnitude test from the registered products
  always_comb begin
    diff    = prr - pii;
    re_t    = {{(SAT_W-64+FRAC_BITS){diff[63]}}, diff[63:FRAC_BITS]}
              + {{(SAT_W-Q_W){cr[Q_W-1]}}, cr};
    im_t    = {{(SAT_W-64+FRAC_BITS-1){pri[63]}}, pri[63:FRAC_BITS-1]}
              + {{(SAT_W-Q_W){ci[Q_W-1]}}, ci};
    nr      = sat_q(re_t);
    ni      = sat_q(im_t);
    mag     = $unsigned(prr) + $unsigned(pii);
    esc_now = (mag >= ESCAPE_MAG);
    last    = (step == IW'(MAX_ITER - 1));
    r_sum   = colr + CRW'(COLOR_R_STEP);
    r_wrap  = (r_sum >= CRW'(MAX_ITER));
  end

  assign pop      = (state == B_IDLE) && !q_stat.empty;
  assign out_free = !out_valid || !out_stall;

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      escape_step <= '0;
      escaped     <= 1'b0;
      rgba_color  <= '0;
    end else begin
      // a beat taken while done refills below instead
      if (out_valid && !out_stall && (state != B_DONE)) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (pop) state <= B_MUL;
        B_MUL:  state <= B_UPD;
        B_UPD: begin
          if (first) state <= B_MUL;
          else if (esc_now || last) state <= B_DONE;
          else state <= B_MUL;
        end
        B_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            escaped     <= hit;
            escape_step <= hit ? 6'(step) : 6'(MAX_ITER);
            rgba_color  <= hit ? (32'(colq) | COLOR_ALPHA) : COLOR_INSIDE;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // iteration datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (pop) begin
          zr    <= qdata.re;
          zi    <= qdata.im;
          cr    <= qdata.re;
          ci    <= qdata.im;
          first <= 1'b1;
          hit   <= 1'b0;
          step  <= '0;
          colq  <= '0;
          colr  <= '0;
        end
      end
      B_MUL: begin
        prr <= zr * zr;
        pii <= zi * zi;
        pri <= zr * zi;
      end
      B_UPD: begin
        if (first) begin
          // seed step: squares of c, nothing to test yet
          zr    <= nr;
          zi    <= ni;
          first <= 1'b0;
        end else if (esc_now) begin
          hit <= 1'b1;
        end else if (!last) begin
          zr   <= nr;
          zi   <= ni;
          step <= step + 1'b1;
          // color = floor(base * step / MAX_ITER), kept incrementally
          colq <= colq + 24'(COLOR_Q_STEP) + 24'(r_wrap);
          colr <= r_wrap ? r_sum - CRW'(MAX_ITER) : r_sum;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: sv/mandelbrot_escape_time_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Maps a pixel to a point c and counts escape steps of z = z*z + c, with
// escape flag and RGBA color.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    pixel_x, pixel_y
//   output    out_valid / out_stall  escape_step, escaped, rgba_color
//   config    cfg_we                 cfg_index, cfg_data
//
// Front: a reciprocal multiply (input register, then registered multiply) for the
// divide by the image size, then one shared 32x33 multiplier used for both axes.
// Back: each step of the z loop runs a multiply stage, then an update/test stage.
// A two-deep queue lets the front map the next pixel while the back iterates.
// Reset loads the register defaults; there is no clearing pass.
// A stalled result waits in the output register; the back waits behind it.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_core_defines.svh"

module mandelbrot_escape_time_pixel_core import mbet_pkg::*; #(
  parameter int unsigned MAX_ITER   = DEF_MAX_ITER,
  parameter int unsigned IMG_WIDTH  = DEF_IMG_WIDTH,
  parameter int unsigned IMG_HEIGHT = DEF_IMG_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     pixel_x,
  input  logic [PIX_W-1:0]     pixel_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [5:0]           escape_step,
  output logic                 escaped,
  output logic [31:0]          rgba_color,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data
);

  cfg_t    cfg;
  q_stat_t q_stat;
  coord_t  q_din;
  coord_t  q_dout;
  logic    q_push;
  logic    q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inverse_scale <= INV_SCALE_RST;
      cfg.offset_x      <= '0;
      cfg.offset_y      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_SCALE: cfg.inverse_scale <= cfg_data;
        REG_OFFSET_X:  cfg.offset_x      <= $signed(cfg_data);
        REG_OFFSET_Y:  cfg.offset_y      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  mbet_front #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pixel_x (pixel_x),
    .pixel_y (pixel_y),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .push    (q_push),
    .coord   (q_din)
  );

  mbet_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .q_stat(q_stat)
  );

  mbet_iter #(.MAX_ITER(MAX_ITER)) u_iter (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .qdata      (q_dout),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .escape_step(escape_step),
    .escaped    (escaped),
    .rgba_color (rgba_color)
  );

  // assertions
  `MBET_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "push into full queue")
  `MBET_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `MBET_ASSERT_IMP(a_inside_result, out_valid && !escaped, escape_step == 6'(MAX_ITER) && rgba_color == COLOR_INSIDE, "bad non-escape result")
  `MBET_ASSERT_NEXT(a_front_busy, in_valid && !in_stall, in_stall, "front took a second beat while mapping")

endmodule

FILE: bench/mandelbrot_escape_time_pixel_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core_tb
// Self-checking bench for the escape-time pixel core. A queue of pixel beats
// feeds a clocked driver. A clocked monitor compares every result beat, field
// by field, with an in-bench fixed-point escape-time calculation. Phases
// cover reset settings, the exact escape boundary, saturated mapping and
// random zoom and pan settings under several idle and stall patterns.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_core_tb;
  import mbet_pkg::*;

  localparam int unsigned MAX_ITER = DEF_MAX_ITER;
  localparam longint      IMG_W    = DEF_IMG_WIDTH;
  localparam longint      IMG_H    = DEF_IMG_HEIGHT;
  localparam longint      Q_MAX_L  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      Q_MIN_L  = -64'sh0000_0000_8000_0000;
  localparam int          LONG_HOLD = 600;
  // index past the register file, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [5:0]  step;
    logic        esc;
    logic [31:0] rgba;
  } escape_res_t;

  // DUT signals, the driven ones known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel_x = '0;
  logic [PIX_W-1:0]     pixel_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [5:0]           escape_step;
  logic                 escaped;
  logic [31:0]          rgba_color;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_data = '0;

  // bench state
  pixel_t      pixel_feed[$];
  escape_res_t expected_px[$];
  logic        [Q_W-1:0] inv_scale_m;
  logic signed [Q_W-1:0] off_x_m;
  logic signed [Q_W-1:0] off_y_m;
  bit          in_took;
  int          fail_count   = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holds_asked  = 0;
  int          holds_done   = 0;
  int          hold_left    = 0;
  pixel_t      next_px;
  escape_res_t want;

  mandelbrot_escape_time_pixel_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .escape_step(escape_step),
    .escaped    (escaped),
    .rgba_color (rgba_color),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // escape-time prediction
  // ---------------------------------------------------------------------------
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX_L) return Q_MAX_L;
    if (v < Q_MIN_L) return Q_MIN_L;
    return v;
  endfunction

  // (p/size - 0.5) * inverse_scale - offset; >>> on a signed value floors
  function automatic longint map_axis(input logic [PIX_W-1:0] p, input longint size,
                                      input longint off);
    longint u;
    u = clamp_q(((longint'(p) << FRAC_BITS) / size) - (longint'(1) << (FRAC_BITS - 1)));
    return clamp_q(((u * longint'({32'b0, inv_scale_m})) >>> FRAC_BITS) - off);
  endfunction

  function automatic escape_res_t escape_of(input logic [PIX_W-1:0] px,
                                            input logic [PIX_W-1:0] py);
    longint      cr, ci, zr, zi, nr, ni;
    logic [63:0] mag;
    escape_res_t r;
    cr = map_axis(px, IMG_W, longint'(off_x_m));
    ci = map_axis(py, IMG_H, longint'(off_y_m));
    zr = cr;
    zi = ci;
    r.step = 6'(MAX_ITER);
    r.esc  = 1'b0;
    r.rgba = COLOR_INSIDE;
    for (int i = 0; i < MAX_ITER && !r.esc; i++) begin
      nr = clamp_q(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = 64'(zr * zr) + 64'(zi * zi);
      if (mag >= ESCAPE_MAG) begin
        r.step = 6'(i);
        r.esc  = 1'b1;
        r.rgba = 32'(((64'(COLOR_BASE) * 64'(i)) / 64'(MAX_ITER)) | 64'(COLOR_ALPHA));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // register mirror, input beat capture, result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst) begin
      inv_scale_m = INV_SCALE_RST;
      off_x_m     = '0;
      off_y_m     = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INV_SCALE: inv_scale_m = cfg_data;
          REG_OFFSET_X:  off_x_m     = cfg_data;
          REG_OFFSET_Y:  off_y_m     = cfg_data;
          default: ;
        endcase
      end
      // result beat
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          $display("%0t: result beat with nothing expected: step %0d esc %0b rgba %h",
                   $time, escape_step, escaped, rgba_color);
          fail_count++;
        end else begin
          want = expected_px.pop_front();
          if (escape_step !== want.step) begin
            $display("%0t: escape_step expected %0d actual %0d", $time, want.step,
                     escape_step);
            fail_count++;
          end
          if (escaped !== want.esc) begin
            $display("%0t: escaped expected %0b actual %0b", $time, want.esc, escaped);
            fail_count++;
          end
          if (rgba_color !== want.rgba) begin
            $display("%0t: rgba_color expected %h actual %h", $time, want.rgba,
                     rgba_color);
            fail_count++;
          end
        end
      end
      // pixel beat
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        expected_px.push_back(escape_of(pixel_x, pixel_y));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_px = pixel_feed.pop_front();
        in_valid <= 1'b1;
        pixel_x  <= next_px.x;
        pixel_y  <= next_px.y;
      end else begin
        // junk on the idle bus
        in_valid <= 1'b0;
        pixel_x  <= PIX_W'($urandom);
        pixel_y  <= PIX_W'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result back-pressure, with an occasional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_px(input int x, input int y);
    pixel_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    pixel_feed.push_back(p);
  endtask

  // mostly inside the image, some indices past its edge
  function automatic int rand_px();
    if ($urandom_range(0, 9) == 0) return $urandom_range(1920, 2047);
    return $urandom_range(0, 1919);
  endfunction

  task automatic push_random(input int n);
    for (int k = 0; k < n; k++) push_px(rand_px(), rand_px());
  endtask

  // everything sent and every result back
  task automatic wait_idle();
    while (pixel_feed.size() != 0 || in_valid || expected_px.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [Q_W-1:0] rand_offset();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
  endfunction

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: field extremes and pixels past the image edge
    push_px(0, 0);
    push_px(2047, 2047);
    push_px(0, 2047);
    push_px(2047, 0);
    push_px(960, 960);
    push_px(1919, 1919);
    push_px(1365, 682);
    push_px(1024, 1);
    push_random(100);
    wait_idle();

    // zero scale: c = -offset; c = (0, 2) lands exactly on |z|^2 = 20
    write_reg(REG_INV_SCALE, 32'h0000_0000);
    write_reg(REG_OFFSET_X, 32'h0000_0000);
    write_reg(REG_OFFSET_Y, 32'hFE00_0000);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    push_px(0, 0);
    push_px(2047, 2047);
    push_px(960, 0);
    wait_idle();
    // one LSB short of the boundary
    write_reg(REG_OFFSET_Y, 32'hFE00_0001);
    push_px(5, 5);
    wait_idle();

    // full-scale zoom and extreme offsets: mapping saturates
    write_reg(REG_INV_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    push_px(0, 0);
    push_px(2047, 2047);
    push_px(0, 2047);
    push_px(2047, 0);
    push_px(960, 960);
    push_random(20);
    wait_idle();
    write_reg(REG_OFFSET_X, 32'h8000_0000);
    write_reg(REG_OFFSET_Y, 32'h7FFF_FFFF);
    push_px(0, 0);
    push_px(2047, 2047);
    push_px(1919, 0);
    push_px(0, 1919);
    push_random(20);
    wait_idle();

    // random views under each idle pattern
    for (int ph = 0; ph < 4; ph++) begin
      if ($urandom_range(0, 4) == 0) write_reg(REG_INV_SCALE, $urandom);
      else write_reg(REG_INV_SCALE, $urandom_range(32'h0040_0000, 32'h0800_0000));
      write_reg(REG_OFFSET_X, rand_offset());
      write_reg(REG_OFFSET_Y, rand_offset());
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 0) holds_asked++;
      push_random(70);
      // sender waits for every result mid-phase
      if (ph == 3) wait_idle();
      push_random(70);
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2 * MAX_ITER + 50) @(posedge clk);
    if (fail_count == 0 && expected_px.size() == 0) begin
      $display("mandelbrot_escape_time_pixel_core verification clean");
    end else begin
      $display("mandelbrot_escape_time_pixel_core verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("mandelbrot_escape_time_pixel_core verification failed");
    $finish;
  end

endmodule
